@@ rtl/nipb_pkg.sv @@
// Shared types, constants and helpers of the nested interval profiler bank.
package nipb_pkg;

  localparam int TIMER_COUNT = 256;
  localparam int TIME_BITS   = 48;
  localparam int DEPTH_BITS  = 8;

  localparam int TIMER_AW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int PROD_W   = TIME_BITS + DEPTH_BITS;

  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_READ  = 2'd2,
    OP_SPARE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_STOP_IDLE = 2'd1,
    ST_DEPTH_SAT = 2'd2
  } status_t;

  // One timer's record as kept in the table.
  typedef struct packed {
    logic                  running;
    logic [DEPTH_BITS-1:0] depth;
    logic [DEPTH_BITS-1:0] peak;
    logic [TIME_BITS-1:0]  start;
    logic [63:0]           total;
    logic [31:0]           hits;
  } timer_entry_t;

  // Clamp the depth-weighted product to 64 bits.
  function automatic logic [63:0] sat_prod(input logic [PROD_W-1:0] prod);
    logic [63:0] res;
    if ((prod >> 64) != '0) res = '1;
    else                    res = 64'(prod);
    return res;
  endfunction

  // Saturating 64-bit add of the charged time to the total.
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] sum;
    logic [63:0] res;
    sum = {1'b0, a} + {1'b0, b};
    if (sum[64]) res = '1;
    else         res = sum[63:0];
    return res;
  endfunction

endpackage

@@ rtl/nipb_store.sv @@
// Timer table: one synchronous memory with per-entry valid bits cleared at reset.
module nipb_store
  import nipb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [TIMER_AW-1:0] rd_addr,
  output timer_entry_t        rd_data,
  input  logic                wr_en,
  input  logic [TIMER_AW-1:0] wr_addr,
  input  timer_entry_t        wr_data
);

  timer_entry_t           mem [TIMER_COUNT];
  logic [TIMER_COUNT-1:0] vld_r;
  timer_entry_t           rd_data_r;
  logic                   rd_vld_r;

  // Valid bits: an entry never written reads as all zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      if (rd_en) rd_vld_r <= vld_r[rd_addr];
    end
  end

  // Memory array with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

@@ rtl/nested_interval_profiler_bank.sv @@
// Top level of the nested interval profiler bank: event sequencer and result register.
//
// Usage: each input beat (in_opcode, in_timer_index, in_now_us) is an event on one
// timer of the bank: start, stop or read. Every event returns exactly one result
// beat with the status and the timer's total, hit count, peak depth and running
// flag as they stand after the event. Both channels use valid/ready.
// Each event runs a read-modify-write of the timer's table entry: the memory read
// as the beat is accepted, the time-times-depth multiply in S_MUL, then the
// saturating add and the write back in S_ADD. A new event is taken only when
// idle or as the current one retires. A following event on the same timer gets
// the written entry by forwarding.
// Reset: all timers read as zero right after reset; per-entry valid bits are
// cleared at once, so no clearing pass is needed and events are taken at once.
// Stall: the result sits in an output register; one more event is accepted and
// read while it waits, and the sequencer then holds until the result is taken.
module nested_interval_profiler_bank
  import nipb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_timer_index,
  input  logic [47:0] in_now_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_total_us,
  output logic [31:0] out_hit_count,
  output logic [7:0]  out_peak_depth,
  output logic        out_is_running
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_ADD} state_t;

  state_t                state_r, state_nxt;
  logic [1:0]            op_r;
  logic                  in_range_r;
  logic [TIMER_AW-1:0]   addr_r;
  logic [TIME_BITS-1:0]  now_r;
  logic                  fwd_r;
  timer_entry_t          fwd_entry_r;
  timer_entry_t          cur_r;
  logic [PROD_W-1:0]     prod_r;

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [63:0]           out_total_r;
  logic [31:0]           out_hits_r;
  logic [7:0]            out_peak_r;
  logic                  out_run_r;

  logic                  accept;
  logic                  done;
  logic [TIMER_AW-1:0]   in_addr;
  timer_entry_t          rd_data;
  timer_entry_t          cur;
  logic [TIME_BITS-1:0]  span;
  logic                  wr_en;
  timer_entry_t          new_entry;
  status_t               status;
  logic [63:0]           charged;

  // Handshake: a new event is taken when idle or as the current one retires.
  assign done     = (state_r == S_ADD) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == S_IDLE) || done;
  assign accept   = in_valid && in_ready;
  assign in_addr  = TIMER_AW'(in_timer_index);

  // Entry as read, or as just written when the previous event hit the same timer.
  assign cur  = fwd_r ? fwd_entry_r : rd_data;
  assign span = now_r - cur.start;

  // Event update of the timer entry.
  always_comb begin
    new_entry = cur_r;
    status    = ST_OK;
    charged   = sat_add(cur_r.total, sat_prod(prod_r));
    unique case (opcode_t'(op_r))
      OP_START: begin
        if (cur_r.running) begin
          new_entry.total = charged;
          if (cur_r.depth == DEPTH_MAX) status = ST_DEPTH_SAT;
          else new_entry.depth = cur_r.depth + 1'b1;
        end else begin
          new_entry.running = 1'b1;
          new_entry.depth   = DEPTH_BITS'(1);
        end
        new_entry.start = now_r;
        if (new_entry.depth > cur_r.peak) new_entry.peak = new_entry.depth;
      end
      OP_STOP: begin
        if (cur_r.running) begin
          new_entry.total = charged;
          if (cur_r.depth != '0) new_entry.depth = cur_r.depth - 1'b1;
          if (new_entry.depth == '0) new_entry.running = 1'b0;
          if (cur_r.hits != '1) new_entry.hits = cur_r.hits + 32'd1;
        end else begin
          status = ST_STOP_IDLE;
        end
      end
      OP_READ, OP_SPARE: begin
        new_entry = cur_r;
      end
      default: new_entry = cur_r;
    endcase
  end

  assign wr_en = done && in_range_r
                 && ((opcode_t'(op_r) == OP_START) || (opcode_t'(op_r) == OP_STOP));

  nipb_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (addr_r),
    .wr_data (new_entry)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   if (accept) state_nxt = S_MUL;
               else if (done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (done) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (accept) fwd_r <= wr_en && (addr_r == in_addr);
      if (done) begin
        if (in_range_r) begin
          out_status_r <= status;
          out_total_r  <= new_entry.total;
          out_hits_r   <= new_entry.hits;
          out_peak_r   <= (32'(new_entry.peak) > 32'd255) ? 8'hFF : 8'(new_entry.peak);
          out_run_r    <= new_entry.running;
        end else begin
          out_status_r <= ST_OK;
          out_total_r  <= '0;
          out_hits_r   <= '0;
          out_peak_r   <= '0;
          out_run_r    <= 1'b0;
        end
      end
    end
  end

  // Event capture and multiply stage.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r        <= in_opcode;
      in_range_r  <= (32'(in_timer_index) < TIMER_COUNT);
      addr_r      <= in_addr;
      now_r       <= TIME_BITS'(in_now_us);
      fwd_entry_r <= new_entry;
    end
    if (state_r == S_MUL) begin
      cur_r  <= cur;
      prod_r <= PROD_W'(span) * PROD_W'(cur.depth);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_total_us   = out_total_r;
  assign out_hit_count  = out_hits_r;
  assign out_peak_depth = out_peak_r;
  assign out_is_running = out_run_r;

endmodule
